// ===== rtl/core/rthg_pkg.sv =====
// shared types for the rgb to hsv converter and gray classifier
`default_nettype none

package rthg_pkg;

    // pixel component and derived widths
    localparam int unsigned COMP_W = 8;
    localparam int unsigned TOT_W  = 18;   // hue dividend, at most 721*255
    localparam int unsigned HDIV_W = 9;    // hue divisor, twice the delta
    localparam int unsigned SDVD_W = 15;   // saturation dividend, delta*100
    localparam int unsigned QUOT_W = 9;    // quotient width of both dividers
    localparam int unsigned HUE_W  = 9;
    localparam int unsigned PCT_W  = 7;

    // hue wrap point
    localparam logic [QUOT_W-1:0] HUE_WRAP = 9'd360;

    // front end to divider hand-off
    typedef struct packed {
        logic              valid;
        logic [TOT_W-1:0]  hue_dvd;
        logic [HDIV_W-1:0] hue_dsr;
        logic [SDVD_W-1:0] sat_dvd;
        logic [COMP_W-1:0] sat_dsr;
        logic [PCT_W-1:0]  val_pct;
        logic              is_gray;
    } t_front;

    // which component is the maximum, and the sign case for red
    typedef enum logic [1:0] {
        SEC_RED_POS,
        SEC_RED_NEG,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

endpackage

`default_nettype wire

// ===== rtl/core/rgb_to_hsv_gray_classify_core.sv =====
// top level of the rgb to hsv converter with black/white/gray flag
`default_nettype none

// Converts one 24-bit RGB pixel per clock into hue in whole degrees (rounded
// half up, 360 wraps to 0), saturation and value in truncated whole percent,
// and a flag for black, white or gray pixels. A transaction is taken on every
// clock edge where start is high; busy stays low, so a new pixel may enter
// each cycle. Each result appears for one cycle with o_valid high after 3
// front-end stages (pixel capture, max/min, divider operands), 9 stages of
// the bit-per-stage hue and saturation dividers, and one output register.
// Results leave in the order the pixels came in; the receiver must take them
// as they appear, since the pipeline cannot be held.
module rgb_to_hsv_gray_classify_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [23:0] i_pixel_rgb,
    output logic             o_valid,
    output logic [8:0]       o_hue_deg,
    output logic [6:0]       o_sat_pct,
    output logic [6:0]       o_val_pct,
    output logic             o_is_gray
);
    import rthg_pkg::*;

    t_front            w_front;
    logic              w_hue_valid, w_sat_valid;
    logic [QUOT_W-1:0] w_hue_q, w_sat_q;
    logic              w_gray_d;
    logic [PCT_W-1:0]  w_val_d;

    logic              r_valid;
    logic [HUE_W-1:0]  r_hue;
    logic [PCT_W-1:0]  r_sat, r_val;
    logic              r_gray;

    assign busy = 1'b0;

    rthg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start & ~busy),
        .i_pixel_rgb (i_pixel_rgb),
        .o_front     (w_front)
    );

    rthg_div #(
        .DVD_W  (TOT_W),
        .DSR_W  (HDIV_W),
        .Q_W    (QUOT_W),
        .SIDE_W (1)
    ) u_hue_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_front.valid),
        .i_dividend (w_front.hue_dvd),
        .i_divisor  (w_front.hue_dsr),
        .i_side     (w_front.is_gray),
        .o_valid    (w_hue_valid),
        .o_quot     (w_hue_q),
        .o_side     (w_gray_d)
    );

    // same depth as the hue divider so both results line up
    rthg_div #(
        .DVD_W  (SDVD_W),
        .DSR_W  (COMP_W),
        .Q_W    (QUOT_W),
        .SIDE_W (PCT_W)
    ) u_sat_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_front.valid),
        .i_dividend (w_front.sat_dvd),
        .i_divisor  (w_front.sat_dsr),
        .i_side     (w_front.val_pct),
        .o_valid    (w_sat_valid),
        .o_quot     (w_sat_q),
        .o_side     (w_val_d)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_hue_valid & w_sat_valid;
        end
        // rounding can reach 360, which wraps to 0
        r_hue  <= (w_hue_q >= HUE_WRAP) ? HUE_W'(w_hue_q - HUE_WRAP) : HUE_W'(w_hue_q);
        r_sat  <= w_sat_q[PCT_W-1:0];
        r_val  <= w_val_d;
        r_gray <= w_gray_d;
    end

    assign o_valid   = r_valid;
    assign o_hue_deg = r_hue;
    assign o_sat_pct = r_sat;
    assign o_val_pct = r_val;
    assign o_is_gray = r_gray;

endmodule

`default_nettype wire

// ===== rtl/core/rthg_front.sv =====
// front end: max/min, sector choice, divider operands, value and gray flag
`default_nettype none

module rthg_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic [23:0]            i_pixel_rgb,
    output rthg_pkg::t_front            o_front
);
    import rthg_pkg::*;

    // stage a: captured pixel
    logic              r_a_valid;
    logic [23:0]       r_a_rgb;

    // stage b: extremes and sector
    logic              r_b_valid;
    logic [COMP_W-1:0] r_b_mx;
    logic [COMP_W-1:0] r_b_d;
    logic signed [8:0] r_b_num;
    t_sector           r_b_sec;

    // stage c: divider operands
    t_front            r_c;

    logic [COMP_W-1:0] w_r, w_g, w_b;
    logic [COMP_W-1:0] n_mx, n_mn;
    logic signed [8:0] n_num;
    t_sector           n_sec;

    always_comb begin
        w_r = r_a_rgb[23:16];
        w_g = r_a_rgb[15:8];
        w_b = r_a_rgb[7:0];
        n_mx = w_r;
        if (w_g > n_mx) n_mx = w_g;
        if (w_b > n_mx) n_mx = w_b;
        n_mn = w_r;
        if (w_g < n_mn) n_mn = w_g;
        if (w_b < n_mn) n_mn = w_b;
        // ties go to red first, then green
        priority if (w_r >= w_g && w_r >= w_b) begin
            n_num = $signed({1'b0, w_g}) - $signed({1'b0, w_b});
            n_sec = (w_g >= w_b) ? SEC_RED_POS : SEC_RED_NEG;
        end else if (w_g >= w_b) begin
            n_num = $signed({1'b0, w_b}) - $signed({1'b0, w_r});
            n_sec = SEC_GREEN;
        end else begin
            n_num = $signed({1'b0, w_r}) - $signed({1'b0, w_g});
            n_sec = SEC_BLUE;
        end
    end

    // 2*offset+1 for the half-up rounding of the hue
    logic [9:0]         w_coef;
    logic signed [18:0] w_num_x, w_d_x, w_coef_x, w_tot;
    logic [SDVD_W-1:0]  w_d100, w_v100;
    logic [15:0]        w_val_sum;
    logic               w_s5, w_s15, w_gt30, w_gt15;
    t_front             n_c;

    always_comb begin
        unique case (r_b_sec)
            SEC_RED_POS: w_coef = 10'd1;
            SEC_RED_NEG: w_coef = 10'd721;
            SEC_GREEN:   w_coef = 10'd241;
            SEC_BLUE:    w_coef = 10'd481;
            default:     w_coef = 10'd1;
        endcase
        w_num_x  = {{10{r_b_num[8]}}, r_b_num};
        w_d_x    = {11'b0, r_b_d};
        w_coef_x = {9'b0, w_coef};
        w_tot    = w_num_x * 19'sd120 + w_coef_x * w_d_x;

        w_d100 = SDVD_W'(r_b_d) * SDVD_W'(100);
        w_v100 = SDVD_W'(r_b_mx) * SDVD_W'(100);
        // exact floor(x/255) for x = max*100, at most 25500
        w_val_sum = 16'(w_v100) + 16'd1 + 16'(w_v100 >> 8);

        w_s5   = w_d100 <= SDVD_W'(r_b_mx) * SDVD_W'(5);
        w_s15  = w_d100 <= SDVD_W'(r_b_mx) * SDVD_W'(15);
        w_gt30 = w_v100 > SDVD_W'(7650);
        w_gt15 = w_v100 > SDVD_W'(3825);

        n_c.valid   = r_b_valid;
        // zero delta or zero max: dividend 0 over divisor 1
        n_c.hue_dvd = (r_b_d != '0) ? w_tot[TOT_W-1:0] : '0;
        n_c.hue_dsr = (r_b_d != '0) ? {r_b_d, 1'b0} : HDIV_W'(1);
        n_c.sat_dvd = w_d100;
        n_c.sat_dsr = (r_b_mx != '0) ? r_b_mx : COMP_W'(1);
        n_c.val_pct = w_val_sum[14:8];
        n_c.is_gray = (w_gt30 & w_s5) | (w_gt15 & ~w_gt30 & w_s15) | ~w_gt15;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c.valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c.valid <= n_c.valid;
        end
        r_a_rgb     <= i_pixel_rgb;
        r_b_mx      <= n_mx;
        r_b_d       <= n_mx - n_mn;
        r_b_num     <= n_num;
        r_b_sec     <= n_sec;
        r_c.hue_dvd <= n_c.hue_dvd;
        r_c.hue_dsr <= n_c.hue_dsr;
        r_c.sat_dvd <= n_c.sat_dvd;
        r_c.sat_dsr <= n_c.sat_dsr;
        r_c.val_pct <= n_c.val_pct;
        r_c.is_gray <= n_c.is_gray;
    end

    assign o_front = r_c;

endmodule

`default_nettype wire

// ===== rtl/core/rthg_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module rthg_div #(
    parameter int unsigned DVD_W  = 18,
    parameter int unsigned DSR_W  = 9,
    parameter int unsigned Q_W    = 9,
    parameter int unsigned SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [DVD_W-1:0]  i_dividend,
    input  wire logic [DSR_W-1:0]  i_divisor,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [Q_W-1:0]         o_quot,
    output logic [SIDE_W-1:0]      o_side
);
    // compare width covers both the remainder and the shifted divisor
    localparam int unsigned CW = (DVD_W > DSR_W + Q_W) ? DVD_W : DSR_W + Q_W;

    logic              r_valid [0:Q_W-1];
    logic [Q_W-1:0]    r_quo   [0:Q_W-1];
    logic [SIDE_W-1:0] r_side  [0:Q_W-1];
    logic [DVD_W-1:0]  r_rem   [0:Q_W-2];
    logic [DSR_W-1:0]  r_dsr   [0:Q_W-2];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        localparam int unsigned K = Q_W - 1 - s;

        logic              w_valid_in;
        logic [DVD_W-1:0]  w_rem_in;
        logic [DSR_W-1:0]  w_dsr_in;
        logic [Q_W-1:0]    w_quo_in;
        logic [SIDE_W-1:0] w_side_in;
        logic [CW-1:0]     w_trial, w_rem_x;
        logic              w_take;

        if (s == 0) begin : g_first
            assign w_valid_in = i_valid;
            assign w_rem_in   = i_dividend;
            assign w_dsr_in   = i_divisor;
            assign w_quo_in   = '0;
            assign w_side_in  = i_side;
        end else begin : g_next
            assign w_valid_in = r_valid[s-1];
            assign w_rem_in   = r_rem[s-1];
            assign w_dsr_in   = r_dsr[s-1];
            assign w_quo_in   = r_quo[s-1];
            assign w_side_in  = r_side[s-1];
        end

        assign w_trial = CW'(w_dsr_in) << K;
        assign w_rem_x = CW'(w_rem_in);
        assign w_take  = w_rem_x >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else begin
                r_valid[s] <= w_valid_in;
            end
            r_quo[s]  <= w_quo_in | (Q_W'(w_take) << K);
            r_side[s] <= w_side_in;
        end

        if (s < Q_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[s] <= w_take ? DVD_W'(w_rem_x - w_trial) : w_rem_in;
                r_dsr[s] <= w_dsr_in;
            end
        end
    end

    assign o_valid = r_valid[Q_W-1];
    assign o_quot  = r_quo[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// testbench for the rgb to hsv converter with black/white/gray classification
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rthg_pkg::*;

    localparam int PIPE_LATENCY = 13;
    localparam int RANDOM_ITEMS = 1330;
    localparam int TAIL_ITEMS   = 150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int FULL_SCALE   = 255;
    localparam int DEG_PER_SEC  = 60;
    localparam int HUE_GREEN    = 120;
    localparam int HUE_BLUE     = 240;
    localparam int V_HIGH_PCT   = 30;
    localparam int V_LOW_PCT    = 15;
    localparam int S_HIGH_PCT   = 5;
    localparam int S_LOW_PCT    = 15;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] val;
        logic             gray;
    } t_hsv;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start = 1'b0;
    logic             busy;
    logic [23:0]      i_pixel_rgb = '0;
    logic             o_valid;
    logic [HUE_W-1:0] o_hue_deg;
    logic [PCT_W-1:0] o_sat_pct;
    logic [PCT_W-1:0] o_val_pct;
    logic             o_is_gray;

    logic [23:0] pixel_queue[$];
    bit          drain_queue[$];
    t_hsv        hsv_expected[$];
    int          idle_left = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    rgb_to_hsv_gray_classify_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_pixel_rgb(i_pixel_rgb),
        .o_valid    (o_valid),
        .o_hue_deg  (o_hue_deg),
        .o_sat_pct  (o_sat_pct),
        .o_val_pct  (o_val_pct),
        .o_is_gray  (o_is_gray)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_hsv predict_hsv(input logic [23:0] px);
        int   r, g, b, mx, mn, d, num, off, tot, h, s, v, v100;
        bit   s5, s15;
        t_hsv res;
        r = px[23:16];
        g = px[15:8];
        b = px[7:0];
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        v = (mx * 100) / FULL_SCALE;
        s = (mx == 0) ? 0 : (d * 100) / mx;
        if (d == 0) begin
            h = 0;
        end else begin
            // ties pick red first, then green
            if (r == mx) begin
                num = g - b;
                off = (g >= b) ? 0 : int'(HUE_WRAP);
            end else if (g == mx) begin
                num = b - r;
                off = HUE_GREEN;
            end else begin
                num = r - g;
                off = HUE_BLUE;
            end
            // round half up on the exact rational
            tot = 2 * DEG_PER_SEC * num + (2 * off + 1) * d;
            h = tot / (2 * d);
            if (h >= int'(HUE_WRAP)) h = h - int'(HUE_WRAP);
        end
        // thresholds compared on exact percentages
        v100 = mx * 100;
        s5  = (mx == 0) || (d * 100 <= S_HIGH_PCT * mx);
        s15 = (mx == 0) || (d * 100 <= S_LOW_PCT * mx);
        res.hue  = h[HUE_W-1:0];
        res.sat  = s[PCT_W-1:0];
        res.val  = v[PCT_W-1:0];
        res.gray = (v100 > V_HIGH_PCT * FULL_SCALE && s5) ||
                   (v100 > V_LOW_PCT * FULL_SCALE && v100 <= V_HIGH_PCT * FULL_SCALE && s15) ||
                   (v100 <= V_LOW_PCT * FULL_SCALE);
        return res;
    endfunction

    function automatic logic [23:0] random_pixel();
        int          base, c0, c1, c2;
        logic [23:0] px;
        case ($urandom_range(0, 5))
            0, 1: px = 24'($urandom);
            2: begin
                // near-achromatic colors around the saturation thresholds
                base = $urandom_range(0, 255);
                c0 = base + $urandom_range(0, 14);
                c1 = base + $urandom_range(0, 14);
                c2 = base + $urandom_range(0, 14);
                if (c0 > 255) c0 = 255;
                if (c1 > 255) c1 = 255;
                if (c2 > 255) c2 = 255;
                px = {c0[7:0], c1[7:0], c2[7:0]};
            end
            3: px = {8'($urandom_range(0, 90)), 8'($urandom_range(0, 90)),
                     8'($urandom_range(0, 90))};
            4: begin
                // two components share the maximum
                c0 = $urandom_range(1, 255);
                c1 = $urandom_range(0, c0);
                case ($urandom_range(0, 2))
                    0: px = {c0[7:0], c0[7:0], c1[7:0]};
                    1: px = {c0[7:0], c1[7:0], c0[7:0]};
                    default: px = {c1[7:0], c0[7:0], c0[7:0]};
                endcase
            end
            default: begin
                // achromatic
                c0 = $urandom_range(0, 255);
                px = {c0[7:0], c0[7:0], c0[7:0]};
            end
        endcase
        return px;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // driver: a transaction is taken on each edge with start high and busy low
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            hsv_expected.push_back(predict_hsv(i_pixel_rgb));
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (idle_left != 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (pixel_queue.size() == 0) begin
                start <= 1'b0;
            end else if (drain_queue[0] && hsv_expected.size() != 0) begin
                start <= 1'b0;
            end else if (pixel_queue.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
                idle_left = $urandom_range(1, 12) - 1;
                start <= 1'b0;
            end else begin
                start <= 1'b1;
                i_pixel_rgb <= pixel_queue.pop_front();
                void'(drain_queue.pop_front());
            end
        end
    end

    // monitor: results cannot be held off
    always @(posedge i_clk) begin
        t_hsv want;
        if (i_rst_n && o_valid) begin
            if (hsv_expected.size() == 0) begin
                report_mismatch("unexpected result, hue", o_hue_deg, 0);
            end else begin
                want = hsv_expected.pop_front();
                if (o_hue_deg !== want.hue) report_mismatch("hue_deg", o_hue_deg, want.hue);
                if (o_sat_pct !== want.sat) report_mismatch("sat_pct", o_sat_pct, want.sat);
                if (o_val_pct !== want.val) report_mismatch("val_pct", o_val_pct, want.val);
                if (o_is_gray !== want.gray) report_mismatch("is_gray", o_is_gray, want.gray);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [23:0] directed[$];
        directed = '{
            24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00, 24'h0000FF,
            24'hFF00FF, 24'hFF0001, 24'hFFFF00, 24'h00FFFF, 24'hFF00FE,
            24'h780100,                          // hue lands exactly on a half degree
            24'h4C4C4C, 24'h4D4D4D,              // value around thirty percent
            24'h262626, 24'h272727,              // value around fifteen percent
            24'hC8BEBE, 24'hC8BDBD,              // saturation around five percent
            24'h3C3333, 24'h3C3232,              // saturation around fifteen percent
            24'h010000, 24'h000001, 24'h7F80FF
        };
        i_rst_n = 1'b0;
        foreach (directed[k]) begin
            pixel_queue.push_back(directed[k]);
            drain_queue.push_back(1'b0);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pixel_queue.push_back(random_pixel());
            // wait for an empty pipeline before the first random item and midway
            drain_queue.push_back(n == 0 || n == RANDOM_ITEMS / 2);
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pixel_queue.size() != 0 || start) @(posedge i_clk);
        while (hsv_expected.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
        if (hsv_expected.size() != 0)
            report_mismatch("leftover expectations", hsv_expected.size(), 0);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
